// ===== src/wwlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Word wrap line counter package
// Shared types, register map, character classes and reset values.
// ----------------------------------------------------------------------------
package wwlc_pkg;

	// defaults for the top level parameters
	localparam int MAX_WORD_CHARS_DEF = 128;
	localparam int COORD_BITS_DEF     = 16;

	// largest advance a single character can add to a word
	localparam int GLYPH_ADV_MAX = 255;

	// queue depths
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	// configuration port
	localparam int ADDR_BITS    = 5;
	localparam int DATA_BITS    = 32;
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LEFT   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_TOP_START     = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_LINE_HEIGHT   = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_SPACE_WIDTH   = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_TAB_WIDTH     = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_FIXED_ADVANCE = 3'd7;

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_WORD_LO = 8'h21;
	localparam logic [7:0] CH_WORD_HI = 8'h7F;
	localparam logic [7:0] CH_HIGH_LO = 8'h80;
	localparam logic [7:0] CH_HIGH_HI = 8'hFF;

	localparam logic [7:0] LINES_MAX = 8'hFF;

	typedef enum logic [2:0] {
		CLS_NUL,
		CLS_TAB,
		CLS_LF,
		CLS_VT,
		CLS_CR,
		CLS_BLANK,
		CLS_WORD,
		CLS_HIGH
	} cls_t;

	// one classified byte on its way from front to back
	typedef struct packed {
		logic              first;
		logic signed [9:0] margin;
		cls_t              cls;
		logic [7:0]        adv;
	} cmd_t;

	typedef struct packed {
		logic [9:0]         window_left;
		logic signed [10:0] top_start;
		logic [9:0]         window_width;
		logic [9:0]         window_height;
		logic [7:0]         line_height;
		logic [7:0]         space_width;
		logic [7:0]         tab_width;
		logic [7:0]         fixed_advance;
	} cfg_t;

	typedef struct packed {
		logic [7:0] line_count;
		logic       finished;
	} res_t;

	localparam cfg_t CFG_RST = '{
		window_left:   10'd0,
		top_start:     11'sd0,
		window_width:  10'd320,
		window_height: 10'd240,
		line_height:   8'd16,
		space_width:   8'd8,
		tab_width:     8'd32,
		fixed_advance: 8'd0
	};

endpackage
`default_nettype wire

// ===== src/wwlc_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out store with full and empty flags; the head is shown
// while not empty.
// ----------------------------------------------------------------------------
module wwlc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ===== src/wwlc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Word wrap front end
// Accepts text bytes, sorts each into a character class, resolves its
// advance and queues the result for the back end.
// ----------------------------------------------------------------------------
module wwlc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wwlc_pkg::cfg_t      cfg,
	input  wire logic                push,
	output logic                     full,
	input  wire logic                first,
	input  wire logic [7:0]          char_code,
	input  wire logic                glyph_present,
	input  wire logic [7:0]          glyph_advance,
	input  wire logic signed [9:0]   margin,
	output wwlc_pkg::cmd_t           cmd,
	output logic                     cmd_empty,
	input  wire logic                cmd_pop
);
	import wwlc_pkg::*;

	cmd_t                in_cmd;
	cls_t                cls;
	logic [$bits(cmd_t)-1:0] head;

	always_comb begin
		unique case (char_code) inside
			CH_NUL:                   cls = CLS_NUL;
			CH_TAB:                   cls = CLS_TAB;
			CH_LF:                    cls = CLS_LF;
			CH_VT:                    cls = CLS_VT;
			CH_CR:                    cls = CLS_CR;
			[CH_WORD_LO:CH_WORD_HI]:  cls = CLS_WORD;
			[CH_HIGH_LO:CH_HIGH_HI]:  cls = CLS_HIGH;
			default:                  cls = CLS_BLANK;
		endcase
	end

	always_comb begin
		in_cmd.first  = first;
		in_cmd.margin = margin;
		in_cmd.cls    = cls;
		// missing glyphs take the blank advance
		if (!glyph_present) begin
			in_cmd.adv = cfg.space_width;
		end else if (cfg.fixed_advance != '0) begin
			in_cmd.adv = cfg.fixed_advance;
		end else begin
			in_cmd.adv = glyph_advance;
		end
	end

	wwlc_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (head),
		.empty   (cmd_empty)
	);

	assign cmd = cmd_t'(head);

endmodule
`default_nettype wire

// ===== src/wwlc_tabmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tab stop remainder unit
// Computes |value| mod divisor, four quotient bits per cycle, restoring.
// ----------------------------------------------------------------------------
module wwlc_tabmod #(
	parameter int COORD_BITS = wwlc_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] value,
	input  wire logic [7:0]                   divisor,
	output logic                              done,
	output logic [7:0]                        rem
);
	localparam int STEP  = 4;
	localparam int MW    = ((COORD_BITS + STEP - 1) / STEP) * STEP;
	localparam int STEPS = MW / STEP;
	localparam int CW    = $clog2(STEPS + 1);

	logic [MW-1:0]         mag_q;
	logic [7:0]            rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COORD_BITS-1:0] mag_in;
	logic [MW-1:0]         m;
	logic [7:0]            r;
	logic [8:0]            r9;

	assign mag_in = value[COORD_BITS-1] ? COORD_BITS'(-value) : COORD_BITS'(value);

	always_comb begin
		m  = mag_q;
		r  = rem_q;
		r9 = '0;
		for (int i = 0; i < STEP; i++) begin
			r9 = {r, m[MW-1]};
			m  = m << 1;
			if (r9 >= {1'b0, divisor}) begin
				r9 = r9 - {1'b0, divisor};
			end
			r = r9[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= MW'(mag_in);
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= m;
			rem_q <= r;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== src/wwlc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Word wrap back end
// Sequencer that applies queued bytes to pen position, open word and line
// count, and pushes one result per byte.
// ----------------------------------------------------------------------------
module wwlc_back #(
	parameter int MAX_WORD_CHARS = wwlc_pkg::MAX_WORD_CHARS_DEF,
	parameter int COORD_BITS     = wwlc_pkg::COORD_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wwlc_pkg::cfg_t cfg,
	input  wire wwlc_pkg::cmd_t cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	input  wire logic           res_full,
	output logic                res_push,
	output wwlc_pkg::res_t      res
);
	import wwlc_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int WW = $clog2(MAX_WORD_CHARS * GLYPH_ADV_MAX + 1);
	localparam int WL = $clog2(MAX_WORD_CHARS + 1);
	localparam int SW = ((CB > WW) ? CB : WW) + 2;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [SW-1:0] sum_t;

	localparam sum_t SAT_HI = sum_t'({1'b0, {(CB - 1){1'b1}}});
	localparam sum_t SAT_LO = -SAT_HI - sum_t'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESTART,
		S_DISP,
		S_COMMIT1,
		S_COMMIT2,
		S_BLANK,
		S_TAB,
		S_WRAP
	} state_t;

	typedef enum logic [1:0] {
		CONT_DISP,
		CONT_BLANK,
		CONT_END
	} cont_t;

	function automatic coord_t sat(input sum_t v);
		coord_t r;
		if (v > SAT_HI) begin
			r = coord_t'(SAT_HI[CB-1:0]);
		end else if (v < SAT_LO) begin
			r = coord_t'(SAT_LO[CB-1:0]);
		end else begin
			r = coord_t'(v[CB-1:0]);
		end
		return r;
	endfunction

	state_t        state_q, state_d;
	cont_t         cont_q, cont_d;
	coord_t        pen_x_q, pen_x_d;
	coord_t        pen_y_q, pen_y_d;
	coord_t        base_q, base_d;
	logic [7:0]    lines_q, lines_d;
	logic [WW-1:0] wwid_q, wwid_d;
	logic [WL-1:0] wlen_q, wlen_d;
	logic          jw_q, jw_d;
	logic          done_q, done_d;
	cmd_t          cur_q;
	cmd_t          it;
	coord_t        lf_y;
	logic [7:0]    lf_lines;
	logic          do_disp;
	logic          do_blank;
	logic          add;
	logic          finish;
	logic          tab_start;
	logic          tab_done;
	logic [7:0]    tab_rem;
	sum_t          tab_adj;

	wwlc_tabmod #(
		.COORD_BITS (CB)
	) u_tabmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (tab_start),
		.value   (pen_x_q),
		.divisor (cfg.tab_width),
		.done    (tab_done),
		.rem     (tab_rem)
	);

	// the byte under work is the queue head while idle, else the held copy
	assign it       = (state_q == S_IDLE) ? cmd : cur_q;
	assign lf_y     = sat(sum_t'(pen_y_q) + sum_t'(cfg.line_height));
	assign lf_lines = (lines_q == LINES_MAX) ? lines_q : lines_q + 8'd1;
	// remainder follows the sign of pen x
	assign tab_adj  = pen_x_q[CB-1] ? sum_t'(tab_rem) : -sum_t'(tab_rem);

	always_comb begin
		state_d   = state_q;
		cont_d    = cont_q;
		pen_x_d   = pen_x_q;
		pen_y_d   = pen_y_q;
		base_d    = base_q;
		lines_d   = lines_q;
		wwid_d    = wwid_q;
		wlen_d    = wlen_q;
		jw_d      = jw_q;
		done_d    = done_q;
		cmd_pop   = 1'b0;
		tab_start = 1'b0;
		finish    = 1'b0;
		do_disp   = 1'b0;
		do_blank  = 1'b0;
		add       = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				// one item at a time; a free result slot guarantees the push
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.first) begin
						state_d = S_RESTART;
					end else begin
						do_disp = 1'b1;
					end
				end
			end
			S_RESTART: begin
				base_d  = sat(sum_t'(cfg.window_left) + sum_t'(cur_q.margin));
				pen_x_d = base_d;
				pen_y_d = sat(sum_t'(cfg.top_start));
				lines_d = 8'd1;
				wwid_d  = '0;
				wlen_d  = '0;
				jw_d    = 1'b0;
				done_d  = 1'b0;
				state_d = S_WRAP;
				cont_d  = CONT_DISP;
			end
			S_DISP: begin
				do_disp = 1'b1;
			end
			S_COMMIT1: begin
				// break before the word unless already at x zero
				if ((sum_t'(pen_x_q) + sum_t'(wwid_q) >= sum_t'(cfg.window_width)) &&
						(pen_x_q != '0)) begin
					pen_x_d = base_q;
					pen_y_d = lf_y;
					lines_d = lf_lines;
				end
				state_d = S_COMMIT2;
			end
			S_COMMIT2: begin
				wwid_d = '0;
				wlen_d = '0;
				if (sum_t'(pen_y_q) >= sum_t'(cfg.window_height)) begin
					done_d = 1'b1;
					finish = 1'b1;
				end else begin
					pen_x_d = sat(sum_t'(pen_x_q) + sum_t'(wwid_q));
					jw_d    = 1'b0;
					state_d = S_WRAP;
				end
			end
			S_BLANK: begin
				do_blank = 1'b1;
			end
			S_TAB: begin
				if (tab_done) begin
					pen_x_d = sat(sum_t'(pen_x_q) + sum_t'(cfg.tab_width) + tab_adj);
					state_d = S_WRAP;
					cont_d  = CONT_END;
				end
			end
			S_WRAP: begin
				if (sum_t'(pen_x_q) >= sum_t'(cfg.window_width)) begin
					pen_x_d = base_q;
					pen_y_d = lf_y;
					lines_d = lf_lines;
					jw_d    = 1'b1;
				end
				if (sum_t'(pen_y_d) >= sum_t'(cfg.window_height)) begin
					done_d = 1'b1;
				end
				unique case (cont_q)
					CONT_DISP: state_d = S_DISP;
					CONT_BLANK: begin
						if (done_d) begin
							finish = 1'b1;
						end else begin
							state_d = S_BLANK;
						end
					end
					default: finish = 1'b1;
				endcase
			end
			default: state_d = S_IDLE;
		endcase

		if (do_disp) begin
			if (done_q) begin
				finish = 1'b1;
			end else if (wlen_q != '0) begin
				if (it.cls == CLS_WORD || it.cls == CLS_HIGH) begin
					add = 1'b1;
				end else begin
					state_d = S_COMMIT1;
					cont_d  = CONT_BLANK;
				end
			end else if (it.cls == CLS_WORD) begin
				add = 1'b1;
			end else begin
				do_blank = 1'b1;
			end
		end

		if (add) begin
			wwid_d = wwid_q + WW'(it.adv);
			wlen_d = wlen_q + WL'(1);
			// a full word closes on its own, with no blank after it
			if (wlen_d == WL'(MAX_WORD_CHARS)) begin
				state_d = S_COMMIT1;
				cont_d  = CONT_END;
			end else begin
				finish = 1'b1;
			end
		end

		if (do_blank) begin
			unique case (it.cls)
				CLS_NUL: begin
					done_d = 1'b1;
					finish = 1'b1;
				end
				CLS_TAB: begin
					if (cfg.tab_width != '0) begin
						tab_start = 1'b1;
						state_d   = S_TAB;
					end else begin
						state_d = S_WRAP;
						cont_d  = CONT_END;
					end
				end
				CLS_LF: begin
					jw_d    = 1'b0;
					pen_x_d = base_q;
					pen_y_d = lf_y;
					lines_d = lf_lines;
					state_d = S_WRAP;
					cont_d  = CONT_END;
				end
				CLS_VT: begin
					jw_d    = 1'b0;
					pen_y_d = lf_y;
					lines_d = lf_lines;
					state_d = S_WRAP;
					cont_d  = CONT_END;
				end
				CLS_CR: begin
					jw_d    = 1'b0;
					pen_x_d = base_q;
					state_d = S_WRAP;
					cont_d  = CONT_END;
				end
				default: begin
					// skip the blank advance right after a wrap
					if (!jw_q) begin
						pen_x_d = sat(sum_t'(pen_x_q) + sum_t'(cfg.space_width));
					end
					state_d = S_WRAP;
					cont_d  = CONT_END;
				end
			endcase
		end

		if (finish) begin
			state_d = S_IDLE;
		end
	end

	assign res_push       = finish;
	assign res.line_count = lines_d;
	assign res.finished   = done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cont_q  <= CONT_END;
			pen_x_q <= '0;
			pen_y_q <= '0;
			base_q  <= '0;
			lines_q <= 8'd1;
			wwid_q  <= '0;
			wlen_q  <= '0;
			jw_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cont_q  <= cont_d;
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
			base_q  <= base_d;
			lines_q <= lines_d;
			wwid_q  <= wwid_d;
			wlen_q  <= wlen_d;
			jw_q    <= jw_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

endmodule
`default_nettype wire

// ===== src/word_wrap_line_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Word wrap line counter
// Counts the lines that greedy word wrapping fills, one text byte per word.
//
// Input channel: push/full with first, char_code, glyph_present,
// glyph_advance and margin. Result channel: empty/pop with line_count and
// finished; every input word yields exactly one result word, in order.
// Window geometry and advances are set through the APB port; the user
// must write them only while idle, which the block does not enforce. A
// character that joins a word, or a NUL, is resolved straight from idle;
// any other blank also passes a wrap check. Closing a word adds a break
// check, an advance, a wrap check and a blank dispatch, less the dispatch
// when a full word closes on its own. A first byte adds a restart, a wrap
// check and a dispatch; a tab waits on the remainder unit, which resolves
// four bits per cycle. The back end runs one word at a time.
// Reset loads the register defaults, empties both queues and starts a text
// at window_left with one line. A stalled receiver fills the 2-deep result
// queue, then the 2-deep input queue, and then full rises.
// ----------------------------------------------------------------------------
module word_wrap_line_counter #(
	parameter int MAX_WORD_CHARS = wwlc_pkg::MAX_WORD_CHARS_DEF,
	parameter int COORD_BITS     = wwlc_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [wwlc_pkg::ADDR_BITS-1:0]     paddr,
	input  wire logic [wwlc_pkg::DATA_BITS-1:0]     pwdata,
	output logic [wwlc_pkg::DATA_BITS-1:0]          prdata,
	output logic                                    pready,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               first,
	input  wire logic [7:0]                         char_code,
	input  wire logic                               glyph_present,
	input  wire logic [7:0]                         glyph_advance,
	input  wire logic signed [9:0]                  margin,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [7:0]                              line_count,
	output logic                                    finished
);
	import wwlc_pkg::*;

	cfg_t                    cfg_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    wr_en;
	cmd_t                    cmd;
	logic                    cmd_empty;
	logic                    cmd_pop;
	logic                    res_full;
	logic                    res_push;
	res_t                    res_in;
	logic [$bits(res_t)-1:0] res_head;
	res_t                    res_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW_LEFT:   cfg_q.window_left   <= pwdata[9:0];
				REG_TOP_START:     cfg_q.top_start     <= pwdata[10:0];
				REG_WINDOW_WIDTH:  cfg_q.window_width  <= pwdata[9:0];
				REG_WINDOW_HEIGHT: cfg_q.window_height <= pwdata[9:0];
				REG_LINE_HEIGHT:   cfg_q.line_height   <= pwdata[7:0];
				REG_SPACE_WIDTH:   cfg_q.space_width   <= pwdata[7:0];
				REG_TAB_WIDTH:     cfg_q.tab_width     <= pwdata[7:0];
				REG_FIXED_ADVANCE: cfg_q.fixed_advance <= pwdata[7:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_LEFT:   prdata = {22'd0, cfg_q.window_left};
			REG_TOP_START:     prdata = {21'd0, cfg_q.top_start};
			REG_WINDOW_WIDTH:  prdata = {22'd0, cfg_q.window_width};
			REG_WINDOW_HEIGHT: prdata = {22'd0, cfg_q.window_height};
			REG_LINE_HEIGHT:   prdata = {24'd0, cfg_q.line_height};
			REG_SPACE_WIDTH:   prdata = {24'd0, cfg_q.space_width};
			REG_TAB_WIDTH:     prdata = {24'd0, cfg_q.tab_width};
			REG_FIXED_ADVANCE: prdata = {24'd0, cfg_q.fixed_advance};
			default:           prdata = '0;
		endcase
	end

	wwlc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.full          (full),
		.first         (first),
		.char_code     (char_code),
		.glyph_present (glyph_present),
		.glyph_advance (glyph_advance),
		.margin        (margin),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop)
	);

	wwlc_back #(
		.MAX_WORD_CHARS (MAX_WORD_CHARS),
		.COORD_BITS     (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	wwlc_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign res_out    = res_t'(res_head);
	assign line_count = res_out.line_count;
	assign finished   = res_out.finished;

endmodule
`default_nettype wire

// ===== dv/line_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line count checker
// Watches the byte, result and APB channels of the word wrap line counter.
// Keeps its own pen, word and window state, works out the line count and
// finished flag for every accepted byte, and compares each popped result word
// in order. Register reads are compared against the values written.
// ----------------------------------------------------------------------------
module line_count_checker
	import wwlc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_BITS-1:0]    paddr,
	input  logic [DATA_BITS-1:0]    pwdata,
	input  logic [DATA_BITS-1:0]    prdata,
	input  logic                    pready,
	input  logic                    push,
	input  logic                    full,
	input  logic                    first,
	input  logic [7:0]              char_code,
	input  logic                    glyph_present,
	input  logic [7:0]              glyph_advance,
	input  logic signed [9:0]       margin,
	input  logic                    empty,
	input  logic                    pop,
	input  logic [7:0]              line_count,
	input  logic                    finished,
	output int                      mismatch_count,
	output int                      pending_count,
	output int                      worked_count,
	output int                      result_count
);

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int WORD_CHARS = MAX_WORD_CHARS_DEF;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	cfg_t        win;
	coord_t      pen_x;
	coord_t      pen_y;
	coord_t      line_x;
	logic [15:0] word_width;
	logic [7:0]  word_chars;
	logic [7:0]  lines;
	logic        wrapped;
	logic        done;

	res_t expected_counts[$];
	int   mismatches;
	int   worked;
	int   checked;

	function automatic coord_t clamp(input int v);
		int hi;
		hi = (1 << (COORD_BITS - 1)) - 1;
		if (v > hi)
			return coord_t'(hi);
		if (v < -hi - 1)
			return coord_t'(-hi - 1);
		return coord_t'(v);
	endfunction

	task automatic new_line();
		pen_y = clamp(int'(pen_y) + int'(win.line_height));
		if (lines != LINES_MAX)
			lines = lines + 8'd1;
	endtask

	task automatic check_wrap();
		if (int'(pen_x) >= int'(win.window_width)) begin
			pen_x = line_x;
			new_line();
			wrapped = 1'b1;
		end
		if (int'(pen_y) >= int'(win.window_height))
			done = 1'b1;
	endtask

	task automatic close_word();
		int w;
		w = int'(word_width);
		// a word that starts at x = 0 never breaks, however wide
		if (int'(pen_x) + w >= int'(win.window_width) && pen_x != 0) begin
			pen_x = line_x;
			new_line();
		end
		if (int'(pen_y) >= int'(win.window_height)) begin
			done = 1'b1;
		end else begin
			pen_x = clamp(int'(pen_x) + w);
			wrapped = 1'b0;
			check_wrap();
		end
		word_width = '0;
		word_chars = '0;
	endtask

	task automatic grow_word(input logic present, input logic [7:0] adv);
		logic [7:0] a;
		if (present)
			a = (win.fixed_advance != 0) ? win.fixed_advance : adv;
		else
			a = win.space_width;
		word_width = word_width + 16'(a);
		word_chars = word_chars + 8'd1;
		if (int'(word_chars) >= WORD_CHARS)
			close_word();
	endtask

	task automatic apply_blank(input logic [7:0] c);
		case (c)
			CH_NUL: begin
				done = 1'b1;
				return;
			end
			CH_TAB: begin
				// remainder keeps the sign of the pen
				if (win.tab_width != 0)
					pen_x = clamp(int'(pen_x) + int'(win.tab_width)
						- int'(pen_x) % int'(win.tab_width));
			end
			CH_LF: begin
				wrapped = 1'b0;
				pen_x = line_x;
				new_line();
			end
			CH_VT: begin
				wrapped = 1'b0;
				new_line();
			end
			CH_CR: begin
				wrapped = 1'b0;
				pen_x = line_x;
			end
			default: begin
				if (!wrapped)
					pen_x = clamp(int'(pen_x) + int'(win.space_width));
			end
		endcase
		check_wrap();
	endtask

	task automatic predict_byte(input logic f, input logic [7:0] c, input logic gp,
			input logic [7:0] adv, input logic signed [9:0] m);
		if (f) begin
			line_x = clamp(int'(win.window_left) + int'(m));
			pen_x = line_x;
			pen_y = clamp(int'(win.top_start));
			lines = 8'd1;
			word_width = '0;
			word_chars = '0;
			wrapped = 1'b0;
			done = 1'b0;
			check_wrap();
		end
		// drop bytes once the text is finished
		if (!done) begin
			worked++;
			if (word_chars > 0) begin
				if (c > CH_SPACE) begin
					grow_word(gp, adv);
				end else begin
					close_word();
					if (!done)
						apply_blank(c);
				end
			end else if (c > CH_SPACE && c < CH_HIGH_LO) begin
				grow_word(gp, adv);
			end else begin
				apply_blank(c);
			end
		end
		expected_counts.push_back('{line_count: lines, finished: done});
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t        want;
		logic [31:0] reg_want;
		logic [31:0] reg_mask;
		int          reg_bits;
		string       reg_name;
		if (!arst_n) begin
			win = CFG_RST;
			line_x = clamp(int'(win.window_left));
			pen_x = line_x;
			pen_y = clamp(int'(win.top_start));
			lines = 8'd1;
			word_width = '0;
			word_chars = '0;
			wrapped = 1'b0;
			done = 1'b0;
			expected_counts.delete();
			mismatches = 0;
			worked = 0;
			checked = 0;
			mismatch_count <= 0;
			pending_count <= 0;
			worked_count <= 0;
			result_count <= 0;
		end else begin
			if (pop && !empty) begin
				checked++;
				if (expected_counts.size() == 0) begin
					$error("unexpected result word: line_count %0d, finished %0d",
						line_count, finished);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					if (line_count !== want.line_count) begin
						$error("line_count: expected %0d, got %0d",
							want.line_count, line_count);
						mismatches++;
					end
					if (finished !== want.finished) begin
						$error("finished: expected %0d, got %0d", want.finished, finished);
						mismatches++;
					end
				end
			end

			if (push && !full)
				predict_byte(first, char_code, glyph_present, glyph_advance, margin);

			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[ADDR_BITS-1:2])
						REG_WINDOW_LEFT:   win.window_left = pwdata[9:0];
						REG_TOP_START:     win.top_start = pwdata[10:0];
						REG_WINDOW_WIDTH:  win.window_width = pwdata[9:0];
						REG_WINDOW_HEIGHT: win.window_height = pwdata[9:0];
						REG_LINE_HEIGHT:   win.line_height = pwdata[7:0];
						REG_SPACE_WIDTH:   win.space_width = pwdata[7:0];
						REG_TAB_WIDTH:     win.tab_width = pwdata[7:0];
						REG_FIXED_ADVANCE: win.fixed_advance = pwdata[7:0];
						default: ;
					endcase
				end else begin
					case (paddr[ADDR_BITS-1:2])
						REG_WINDOW_LEFT: begin
							reg_want = 32'(win.window_left);
							reg_bits = $bits(win.window_left);
							reg_name = "window_left";
						end
						REG_TOP_START: begin
							reg_want = 32'(win.top_start);
							reg_bits = $bits(win.top_start);
							reg_name = "top_start";
						end
						REG_WINDOW_WIDTH: begin
							reg_want = 32'(win.window_width);
							reg_bits = $bits(win.window_width);
							reg_name = "window_width";
						end
						REG_WINDOW_HEIGHT: begin
							reg_want = 32'(win.window_height);
							reg_bits = $bits(win.window_height);
							reg_name = "window_height";
						end
						REG_LINE_HEIGHT: begin
							reg_want = 32'(win.line_height);
							reg_bits = $bits(win.line_height);
							reg_name = "line_height";
						end
						REG_SPACE_WIDTH: begin
							reg_want = 32'(win.space_width);
							reg_bits = $bits(win.space_width);
							reg_name = "space_width";
						end
						REG_TAB_WIDTH: begin
							reg_want = 32'(win.tab_width);
							reg_bits = $bits(win.tab_width);
							reg_name = "tab_width";
						end
						default: begin
							reg_want = 32'(win.fixed_advance);
							reg_bits = $bits(win.fixed_advance);
							reg_name = "fixed_advance";
						end
					endcase
					reg_mask = (32'd1 << reg_bits) - 32'd1;
					if ((prdata & reg_mask) !== (reg_want & reg_mask)) begin
						$error("%s: expected %0h, got %0h", reg_name,
							reg_want & reg_mask, prdata & reg_mask);
						mismatches++;
					end
				end
			end

			mismatch_count <= mismatches;
			pending_count <= expected_counts.size();
			worked_count <= worked;
			result_count <= checked;
		end
	end

endmodule

// ===== dv/word_wrap_line_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word wrap line counter testbench
// Drives text bytes and window settings into the line counter with random
// gaps and stalls on both channels. A directed burst covers every byte class
// and restart case, then random texts run under a series of window settings
// from one extreme to the other. The line count checker judges every result.
// ----------------------------------------------------------------------------
module word_wrap_line_counter_tb
	import wwlc_pkg::*;
;

	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_BYTES  = 220;
	localparam int PHASES       = 9;

	typedef enum int {
		SET_LOW,
		SET_HIGH,
		SET_TOP_HIGH,
		SET_WILD,
		SET_RESET,
		SET_TYPICAL
	} window_set_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;
	logic                  push;
	logic                  full;
	logic                  first;
	logic [7:0]            char_code;
	logic                  glyph_present;
	logic [7:0]            glyph_advance;
	logic signed [9:0]     margin;
	logic                  empty;
	logic                  pop;
	logic [7:0]            line_count;
	logic                  finished;

	int mismatch_count;
	int pending_count;
	int worked_count;
	int result_count;

	int   sent_count;
	int   quiet_cycles;
	logic send_idle;
	logic recv_idle;
	logic start_pending;

	word_wrap_line_counter i_dut (.*);

	line_count_checker i_line_check (.*);

	always #4 clk = ~clk;

	task automatic push_byte(input logic f, input logic [7:0] c, input logic gp,
			input logic [7:0] adv, input logic signed [9:0] m);
		int gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		first <= f;
		char_code <= c;
		glyph_present <= gp;
		glyph_advance <= adv;
		margin <= m;
		do @(posedge clk); while (full);
		sent_count++;
	endtask

	// random glyph data and margin around a chosen byte
	task automatic push_glyph(input logic [7:0] c);
		logic              gp;
		logic [7:0]        adv;
		logic signed [9:0] m;
		gp = ($urandom_range(0, 9) != 0);
		adv = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(2, 16)) : 8'($urandom);
		if ($urandom_range(0, 2) != 0)
			m = 10'(int'($urandom_range(0, 96)) - 32);
		else
			m = 10'($urandom);
		push_byte(start_pending, c, gp, adv, m);
		start_pending = 1'b0;
	endtask

	// hold the sender until every result word is back, then let the block settle
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [REG_IDX_BITS-1:0] idx,
			input logic [DATA_BITS-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int stall;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_idle ? $urandom_range(0, 9) : 0;
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		cfg_t        win;
		logic [31:0] regval [2**REG_IDX_BITS];
		window_set_t kind;
		int          target;
		int          sent_start;
		int          n_words;
		int          len;
		int          n_sep;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		first = 1'b0;
		char_code = '0;
		glyph_present = 1'b0;
		glyph_advance = '0;
		margin = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		start_pending = 1'b0;
		sent_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// counting straight from reset, no restart yet
		push_byte(1'b0, "H", 1'b1, 8'd8, 0);
		push_byte(1'b0, CH_HIGH_HI, 1'b1, 8'd255, 0);
		push_byte(1'b0, "x", 1'b0, 8'd0, 0);
		push_byte(1'b0, CH_SPACE, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_TAB, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_HIGH_LO, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_LF, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_VT, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_CR, 1'b1, 8'd0, 0);
		push_byte(1'b0, 8'h01, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_WORD_HI, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_NUL, 1'b1, 8'd0, 0);
		// ignored after the finish
		push_byte(1'b0, "A", 1'b1, 8'd4, 0);
		// restart past the right edge wraps before the byte
		push_byte(1'b1, "A", 1'b1, 8'd255, 511);
		push_byte(1'b0, CH_SPACE, 1'b1, 8'd0, 0);
		// tabs from a negative pen
		push_byte(1'b1, CH_TAB, 1'b1, 8'd0, -512);
		push_byte(1'b0, CH_TAB, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_SPACE, 1'b1, 8'd0, 0);
		push_byte(1'b1, CH_NUL, 1'b0, 8'd0, 0);
		push_byte(1'b1, CH_WORD_LO, 1'b1, 8'd0, 0);
		push_byte(1'b0, CH_SPACE, 1'b1, 8'd0, 0);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			kind = (p < int'(SET_TYPICAL)) ? window_set_t'(p) : SET_TYPICAL;
			case (kind)
				SET_LOW: begin
					win = '0;
					win.top_start = -1024;
				end
				SET_HIGH: begin
					win = '1;
					win.top_start = -1024;
				end
				SET_TOP_HIGH: begin
					win = CFG_RST;
					win.top_start = 1023;
				end
				SET_WILD: begin
					win.window_left = 10'($urandom);
					win.top_start = 11'($urandom);
					win.window_width = 10'($urandom);
					win.window_height = 10'($urandom);
					win.line_height = 8'($urandom);
					win.space_width = 8'($urandom);
					win.tab_width = 8'($urandom_range(1, 255));
					win.fixed_advance = 8'($urandom);
				end
				SET_RESET: win = CFG_RST;
				default: begin
					win.window_left = 10'($urandom_range(0, 200));
					win.top_start = 11'(int'($urandom_range(0, 64)) - 32);
					win.window_width = 10'($urandom_range(96, 1023));
					win.window_height = 10'($urandom_range(120, 1023));
					win.line_height = 8'($urandom_range(8, 40));
					win.space_width = 8'($urandom_range(2, 16));
					win.tab_width = 8'($urandom_range(8, 64));
					win.fixed_advance = ($urandom_range(0, 2) == 0) ?
						8'($urandom_range(4, 16)) : '0;
				end
			endcase
			regval[REG_WINDOW_LEFT] = 32'(win.window_left);
			regval[REG_TOP_START] = 32'(win.top_start);
			regval[REG_WINDOW_WIDTH] = 32'(win.window_width);
			regval[REG_WINDOW_HEIGHT] = 32'(win.window_height);
			regval[REG_LINE_HEIGHT] = 32'(win.line_height);
			regval[REG_SPACE_WIDTH] = 32'(win.space_width);
			regval[REG_TAB_WIDTH] = 32'(win.tab_width);
			regval[REG_FIXED_ADVANCE] = 32'(win.fixed_advance);
			for (int r = 0; r < 2**REG_IDX_BITS; r++)
				apb_xfer(1'b1, REG_IDX_BITS'(r), regval[r]);
			for (int r = 0; r < 2**REG_IDX_BITS; r++)
				apb_xfer(1'b0, REG_IDX_BITS'(r), '0);
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;

			// a top past the window finishes every text at once: keep it short
			target = (kind == SET_TOP_HIGH) ? 20 : PHASE_BYTES;
			sent_start = sent_count;
			while (sent_count - sent_start < target) begin
				start_pending = ($urandom_range(0, 19) != 0);
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
				n_words = $urandom_range(1, 24);
				for (int w = 0; w < n_words && sent_count - sent_start < target; w++) begin
					len = ($urandom_range(0, 79) == 0) ?
						$urandom_range(100, 140) : $urandom_range(1, 12);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 6) != 0)
							push_glyph(8'($urandom_range(CH_WORD_LO, CH_WORD_HI)));
						else
							push_glyph(8'($urandom_range(CH_WORD_LO, CH_HIGH_HI)));
					end
					n_sep = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
					for (int s = 0; s < n_sep; s++) begin
						case ($urandom_range(0, 9))
							0: push_glyph(CH_TAB);
							1: push_glyph(CH_LF);
							2: push_glyph(CH_VT);
							3: push_glyph(CH_CR);
							4: push_glyph(8'($urandom_range(1, CH_SPACE)));
							5: push_glyph(8'($urandom_range(CH_HIGH_LO, CH_HIGH_HI)));
							default: push_glyph(CH_SPACE);
						endcase
					end
					// stray byte, now and then a stray restart
					if ($urandom_range(0, 19) == 0) begin
						start_pending = ($urandom_range(0, 7) == 0);
						push_glyph(8'($urandom));
					end
				end
				if ($urandom_range(0, 4) < 3)
					push_glyph(CH_NUL);
				if ($urandom_range(0, 29) == 0)
					drain_results();
			end
			drain_results();
		end

		$display("%0d bytes pushed, %0d advanced the counter, %0d result words checked",
			sent_count, worked_count, result_count);
		$display("window settings: reset, both extremes, top past the window, wide, typical");
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
src/wwlc_pkg.sv
src/wwlc_fifo.sv
src/wwlc_front.sv
src/wwlc_tabmod.sv
src/wwlc_back.sv
src/word_wrap_line_counter.sv
dv/line_count_checker.sv
dv/word_wrap_line_counter_tb.sv
